### src/bc_pkg.sv
// ----------------------------------------------------------------------------
// bc_pkg: shared types and constants for the binomial coefficient block
// Holds the request and result structs, status codes and controller commands.
// ----------------------------------------------------------------------------
package bc_pkg;

	localparam int unsigned DIVISOR_SLOTS = 128;
	localparam int unsigned SLOT_AW = $clog2(DIVISOR_SLOTS);

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_RANGE    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [7:0] n_value;
		logic [7:0] k_value;
	} bc_req_t;

	typedef struct packed {
		logic [63:0] coefficient;
		logic [1:0]  status;
	} bc_res_t;

	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_LOAD     = 4'd1,
		OP_INIT     = 4'd2,
		OP_OVF      = 4'd3,
		OP_MUL      = 4'd4,
		OP_SLOTRD   = 4'd5,
		OP_GCDSTART = 4'd6,
		OP_REDSTART = 4'd7,
		OP_FINSTART = 4'd8
	} bc_op_t;

	typedef struct packed {
		bc_op_t            op;
		logic [SLOT_AW-1:0] addr;
		logic [8:0]        factor;
	} bc_cmd_t;

	typedef struct packed {
		logic       busy;
		logic       ovf;
	} bc_stat_t;

endpackage

### src/binomial_coefficient.sv
// k above n, n zero, k zero or k equal to n: result given directly; otherwise min(k, n-k) slot
// loads, then per factor an overflow check and a gcd reduction per slot, then a division per slot
// every division runs on the shared divider
// throughput: one request at a time, next accepted once the result is taken
// reset: arst_n clears the controller; divisor slots are reloaded per request
// ----------------------------------------------------------------------------
// binomial_coefficient: n choose k for byte arguments, 64-bit result
// Controller sequences factors and gcd reductions over a divider datapath.
// ----------------------------------------------------------------------------
module binomial_coefficient (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bc_pkg::bc_req_t in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output bc_pkg::bc_res_t out_data
);
	import bc_pkg::*;

	bc_cmd_t  cmd;
	bc_stat_t stat;
	logic [63:0] prod;

	bc_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .cmd(cmd), .stat(stat), .prod(prod)
	);

	bc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .prod(prod)
	);
endmodule

### src/bc_divider.sv
// ----------------------------------------------------------------------------
// bc_divider: restoring divider, 64-bit dividend by 64-bit divisor
// One quotient bit per cycle; divide by zero yields all-ones quotient.
// ----------------------------------------------------------------------------
module bc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);
	logic [6:0]  cnt_q;
	logic [63:0] q_q, r_q, d_q;
	logic [64:0] trial;

	assign trial = {r_q, q_q[63]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign busy      = (cnt_q != 7'd0);
	assign quotient  = q_q;
	assign remainder = r_q;
endmodule

### src/bc_datapath.sv
// ----------------------------------------------------------------------------
// bc_datapath: product register, divisor slots, gcd and division sequencing
// Runs gcd reductions and final divisions on one shared divider.
// ----------------------------------------------------------------------------
module bc_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  bc_pkg::bc_cmd_t cmd,
	output bc_pkg::bc_stat_t stat,
	output logic [63:0]     prod
);
	import bc_pkg::*;

	typedef enum logic [6:0] {
		D_IDLE  = 7'b0000001,
		D_EUC   = 7'b0000010,
		D_EUCW  = 7'b0000100,
		D_DIVP  = 7'b0001000,
		D_DIVPW = 7'b0010000,
		D_DIVS  = 7'b0100000,
		D_DIVSW = 7'b1000000
	} dstate_t;

	logic [7:0]        mem [DIVISOR_SLOTS];
	logic [7:0]        rd_q;
	logic [63:0]       prod_q, a_q, b_q, g_q;
	logic [SLOT_AW-1:0] addr_q;
	logic              fin_q;
	dstate_t           st_q;
	logic              dv_start, dv_busy;
	logic [63:0]       dv_n, dv_d, dv_quo, dv_rem;
	logic [72:0]       mprod;
	logic              wr_en;
	logic [7:0]        wr_data;
	logic [SLOT_AW-1:0] wr_addr;
	logic [7:0]        slot_cur_q;

	bc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_n),
		.divisor(dv_d), .busy(dv_busy), .quotient(dv_quo), .remainder(dv_rem)
	);

	assign mprod = {9'd0, prod_q} * {64'd0, cmd.factor};

	always_comb begin
		dv_start = 1'b0;
		dv_n = a_q;
		dv_d = b_q;
		case (st_q)
			D_EUC: dv_start = (b_q != 64'd0);
			D_DIVP: begin
				dv_start = 1'b1;
				dv_n = prod_q;
				dv_d = g_q;
			end
			// slot divided by the same gcd
			D_DIVS: begin
				dv_start = 1'b1;
				dv_n = {56'd0, slot_cur_q};
				dv_d = g_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = addr_q;
		wr_data = dv_quo[7:0];
		if (cmd.op == OP_LOAD) begin
			wr_en = 1'b1;
			wr_addr = cmd.addr;
			wr_data = 8'({1'b0, cmd.addr} + 8'd1);
		end else if (st_q == D_DIVSW && !dv_busy) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[cmd.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
		end else begin
			case (st_q)
				D_IDLE: begin
					if (cmd.op == OP_REDSTART) st_q <= D_EUC;
					else if (cmd.op == OP_FINSTART)
						st_q <= (rd_q != 8'd0) ? D_DIVP : D_IDLE;
				end
				D_EUC:   st_q <= (b_q == 64'd0) ? D_DIVP : D_EUCW;
				D_EUCW:  if (!dv_busy) st_q <= D_EUC;
				D_DIVP:  st_q <= D_DIVPW;
				D_DIVPW: if (!dv_busy) st_q <= fin_q ? D_IDLE : D_DIVS;
				D_DIVS:  st_q <= D_DIVSW;
				D_DIVSW: if (!dv_busy) st_q <= D_IDLE;
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_INIT) prod_q <= 64'd1;
		if (cmd.op == OP_MUL) prod_q <= mprod[63:0];
		case (st_q)
			D_IDLE: begin
				addr_q <= cmd.addr;
				if (cmd.op == OP_REDSTART) begin
					a_q <= prod_q;
					b_q <= {56'd0, rd_q};
					fin_q <= 1'b0;
				end else if (cmd.op == OP_FINSTART) begin
					g_q <= {56'd0, rd_q};
					fin_q <= 1'b1;
				end
			end
			D_EUC: if (b_q == 64'd0) g_q <= (a_q == 64'd0) ? 64'd1 : a_q;
			D_EUCW: if (!dv_busy) begin
				a_q <= b_q;
				b_q <= dv_rem;
			end
			D_DIVPW: if (!dv_busy) prod_q <= dv_quo;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == D_IDLE && cmd.op == OP_REDSTART) slot_cur_q <= rd_q;
	end

	assign prod = prod_q;
	assign stat.busy = (st_q != D_IDLE);
	assign stat.ovf = (mprod[72:64] != 9'd0);
endmodule

### src/bc_controller.sv
// ----------------------------------------------------------------------------
// bc_controller: sequencer for n choose k
// Loads divisors, steps through factors and slots, issues datapath commands.
// ----------------------------------------------------------------------------
module bc_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bc_pkg::bc_req_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bc_pkg::bc_res_t   out_data,
	output bc_pkg::bc_cmd_t   cmd,
	input  bc_pkg::bc_stat_t  stat,
	input  logic [63:0]       prod
);
	import bc_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_LOAD   = 9'b000000010,
		S_OVF    = 9'b000000100,
		S_RED_RD = 9'b000001000,
		S_RED    = 9'b000010000,
		S_REDW   = 9'b000100000,
		S_FIN_RD = 9'b001000000,
		S_FIN    = 9'b010000000,
		S_FINW   = 9'b100000000
	} state_t;

	state_t            st_q;
	logic [7:0]        k_q, i_q, j_q;
	logic [8:0]        np1_q;
	logic [8:0]        factor;
	logic              res_valid_q;
	bc_res_t           res_q;
	logic              wait_q;
	logic [7:0]        kk;

	assign factor = (np1_q - {1'b0, i_q} == 9'd0) ? 9'd1 : np1_q - {1'b0, i_q};
	assign kk = (in_data.n_value - in_data.k_value < in_data.k_value) ?
		in_data.n_value - in_data.k_value : in_data.k_value;

	assign in_stall = (st_q != S_IDLE) || res_valid_q;
	assign out_valid = res_valid_q;
	assign out_data = res_q;

	always_comb begin
		cmd.op = OP_NONE;
		cmd.addr = j_q[SLOT_AW-1:0];
		cmd.factor = factor;
		case (st_q)
			S_IDLE:   cmd.op = (in_valid && !in_stall) ? OP_INIT : OP_NONE;
			S_LOAD:   cmd.op = OP_LOAD;
			S_OVF:    cmd.op = stat.ovf ? OP_NONE : OP_MUL;
			S_RED:    cmd.op = OP_REDSTART;
			S_FIN:    cmd.op = OP_FINSTART;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res_valid_q <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			if (res_valid_q && !out_stall) res_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					k_q <= kk;
					np1_q <= {1'b0, in_data.n_value} + 9'd1;
					i_q <= kk;
					j_q <= 8'd0;
					if (in_data.k_value > in_data.n_value) begin
						res_q <= '{64'd0, STATUS_RANGE};
						res_valid_q <= 1'b1;
					end else if (in_data.n_value == 8'd0 || kk == 8'd0) begin
						res_q <= '{64'd1, STATUS_OK};
						res_valid_q <= 1'b1;
					end else begin
						st_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (j_q + 8'd1 == k_q) st_q <= S_OVF;
					j_q <= j_q + 8'd1;
				end
				S_OVF: begin
					if (stat.ovf) begin
						res_q <= '{64'd0, STATUS_OVERFLOW};
						res_valid_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						j_q <= k_q - 8'd1;
						st_q <= S_RED_RD;
					end
				end
				S_RED_RD: st_q <= S_RED;
				S_RED: begin
					wait_q <= 1'b1;
					st_q <= S_REDW;
				end
				S_REDW: begin
					wait_q <= 1'b0;
					if (!wait_q && !stat.busy) begin
						if (j_q != 8'd0) begin
							j_q <= j_q - 8'd1;
							st_q <= S_RED_RD;
						end else if (i_q != 8'd1) begin
							i_q <= i_q - 8'd1;
							st_q <= S_OVF;
						end else begin
							j_q <= k_q - 8'd1;
							st_q <= S_FIN_RD;
						end
					end
				end
				S_FIN_RD: st_q <= S_FIN;
				S_FIN: begin
					wait_q <= 1'b1;
					st_q <= S_FINW;
				end
				S_FINW: begin
					wait_q <= 1'b0;
					if (!wait_q && !stat.busy) begin
						if (j_q != 8'd0) begin
							j_q <= j_q - 8'd1;
							st_q <= S_FIN_RD;
						end else begin
							res_q <= '{prod, STATUS_OK};
							res_valid_q <= 1'b1;
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/bc_checker.sv
// ----------------------------------------------------------------------------
// bc_checker: port-level checks for the binomial coefficient block
// Watches handshakes and result codes at the top level.
// ----------------------------------------------------------------------------
module bc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input bc_pkg::bc_req_t in_data,
	input logic            out_valid,
	input logic            out_stall,
	input bc_pkg::bc_res_t out_data
);
	import bc_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// no new request while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request accepted with result pending");

	// error results carry a zero coefficient
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_OK |-> out_data.coefficient == 64'd0)
		else $error("error result nonzero");

	// k above n reports out of range next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.k_value > in_data.n_value
		|=> out_valid && out_data.status == STATUS_RANGE)
		else $error("range case missed");
endmodule

bind binomial_coefficient bc_checker u_bc_checker (.*);
